// ----- design/risc_instruction_decoder_core_assert.svh -----
// Assertion macros for the instruction decoder checker.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef RISC_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define RISC_INSTRUCTION_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define RID_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RID_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/rid_pkg.sv -----
package rid_pkg;

	localparam logic [31:0] RESET_START_ADDR = 32'h0040_0000;
	localparam int          QUEUE_DEPTH_DEF  = 4;

	// dense mnemonic codes
	typedef enum logic [5:0] {
		MN_SLL, MN_SRL, MN_SRA, MN_SLLV, MN_SRLV, MN_SRAV, MN_JR, MN_JALR,
		MN_SYSCALL, MN_BREAK, MN_MFHI, MN_MTHI, MN_MFLO, MN_MTLO,
		MN_MULT, MN_MULTU, MN_DIV, MN_DIVU,
		MN_ADD, MN_ADDU, MN_SUB, MN_SUBU, MN_AND, MN_OR, MN_XOR, MN_NOR,
		MN_SLT, MN_SLTU,
		MN_J, MN_JAL,
		MN_BLTZ, MN_BGEZ, MN_BEQ, MN_BNE, MN_BLEZ, MN_BGTZ,
		MN_ADDI, MN_ADDIU, MN_SLTI, MN_SLTIU, MN_ANDI, MN_ORI, MN_XORI, MN_LUI,
		MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU, MN_SB, MN_SH, MN_SW,
		MN_LWC1, MN_SWC1,
		MN_ADD_S, MN_CVT_S_W
	} mnem_t;

	// primary opcodes given names, most of which need more than a plain lookup
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_COP1    = 6'h11;

	localparam logic [4:0] RT_BLTZ   = 5'd0;
	localparam logic [4:0] RT_BGEZ   = 5'd1;
	localparam logic [4:0] RT_ZERO   = 5'd0;
	localparam logic [5:0] FN_ADD_S  = 6'h00;
	localparam logic [5:0] FN_CVT_SW = 6'h20;

	typedef struct packed {
		logic  known;
		mnem_t mnem;
	} rid_class_t;

	// front to back queue entry
	typedef struct packed {
		logic [31:0] addr;
		logic        known;
		mnem_t       mnem;
		logic [31:0] word;
	} rid_dec_t;

	// one finished result
	typedef struct packed {
		logic [31:0]        addr;
		logic               known;
		mnem_t              mnem;
		logic [4:0]         rs;
		logic [4:0]         rt;
		logic [4:0]         rd;
		logic [4:0]         shamt;
		logic signed [15:0] imm;
		logic [25:0]        jidx;
		logic [31:0]        btgt;
	} rid_res_t;

	function automatic rid_class_t rid_classify(logic [31:0] word);
		rid_class_t c;
		logic [5:0] op;
		logic [5:0] fn;
		logic [4:0] rt;
		op      = word[31:26];
		fn      = word[5:0];
		rt      = word[20:16];
		c.known = 1'b1;
		c.mnem  = MN_SLL;
		case (op)
			OP_SPECIAL: begin
				// function field lookup
				case (fn)
					6'h00: c.mnem = MN_SLL;
					6'h02: c.mnem = MN_SRL;
					6'h03: c.mnem = MN_SRA;
					6'h04: c.mnem = MN_SLLV;
					6'h06: c.mnem = MN_SRLV;
					6'h07: c.mnem = MN_SRAV;
					6'h08: c.mnem = MN_JR;
					6'h09: c.mnem = MN_JALR;
					6'h0c: c.mnem = MN_SYSCALL;
					6'h0d: c.mnem = MN_BREAK;
					6'h10: c.mnem = MN_MFHI;
					6'h11: c.mnem = MN_MTHI;
					6'h12: c.mnem = MN_MFLO;
					6'h13: c.mnem = MN_MTLO;
					6'h18: c.mnem = MN_MULT;
					6'h19: c.mnem = MN_MULTU;
					6'h1a: c.mnem = MN_DIV;
					6'h1b: c.mnem = MN_DIVU;
					6'h20: c.mnem = MN_ADD;
					6'h21: c.mnem = MN_ADDU;
					6'h22: c.mnem = MN_SUB;
					6'h23: c.mnem = MN_SUBU;
					6'h24: c.mnem = MN_AND;
					6'h25: c.mnem = MN_OR;
					6'h26: c.mnem = MN_XOR;
					6'h27: c.mnem = MN_NOR;
					6'h2a: c.mnem = MN_SLT;
					6'h2b: c.mnem = MN_SLTU;
					default: c.known = 1'b0;
				endcase
			end
			OP_REGIMM: begin
				if (rt == RT_BLTZ) begin
					c.mnem = MN_BLTZ;
				end else if (rt == RT_BGEZ) begin
					c.mnem = MN_BGEZ;
				end else begin
					c.known = 1'b0;
				end
			end
			OP_J:    c.mnem = MN_J;
			OP_JAL:  c.mnem = MN_JAL;
			OP_BLEZ: begin
				c.mnem  = MN_BLEZ;
				c.known = (rt == RT_ZERO);
			end
			OP_BGTZ: begin
				c.mnem  = MN_BGTZ;
				c.known = (rt == RT_ZERO);
			end
			OP_COP1: begin
				if (fn == FN_ADD_S) begin
					c.mnem = MN_ADD_S;
				end else if (fn == FN_CVT_SW) begin
					c.mnem = MN_CVT_S_W;
				end else begin
					c.known = 1'b0;
				end
			end
			6'h04: c.mnem = MN_BEQ;
			6'h05: c.mnem = MN_BNE;
			6'h08: c.mnem = MN_ADDI;
			6'h09: c.mnem = MN_ADDIU;
			6'h0a: c.mnem = MN_SLTI;
			6'h0b: c.mnem = MN_SLTIU;
			6'h0c: c.mnem = MN_ANDI;
			6'h0d: c.mnem = MN_ORI;
			6'h0e: c.mnem = MN_XORI;
			6'h0f: c.mnem = MN_LUI;
			6'h20: c.mnem = MN_LB;
			6'h21: c.mnem = MN_LH;
			6'h23: c.mnem = MN_LW;
			6'h24: c.mnem = MN_LBU;
			6'h25: c.mnem = MN_LHU;
			6'h28: c.mnem = MN_SB;
			6'h29: c.mnem = MN_SH;
			6'h2b: c.mnem = MN_SW;
			6'h31: c.mnem = MN_LWC1;
			6'h39: c.mnem = MN_SWC1;
			default: c.known = 1'b0;
		endcase
		// unrecognised words report code zero
		if (!c.known) begin
			c.mnem = MN_SLL;
		end
		return c;
	endfunction

endpackage

// ----- design/rid_front.sv -----
module rid_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr,
	input  logic [31:0]       cfg_data,
	input  logic              push,
	output logic              full,
	input  logic [31:0]       instr_word,
	output logic              out_valid,
	input  logic              out_ready,
	output rid_pkg::rid_dec_t out_dec
);
	import rid_pkg::*;

	logic        vld_s1;
	rid_dec_t    dec_s1;
	logic [31:0] pc_q;
	logic        accept;
	rid_class_t  cls;

	assign full      = vld_s1 && !out_ready;
	assign accept    = push && !full;
	assign cls       = rid_classify(instr_word);
	assign out_valid = vld_s1;
	assign out_dec   = dec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= RESET_START_ADDR;
		end else if (cfg_wr) begin
			pc_q <= cfg_data;
		end else if (accept) begin
			pc_q <= pc_q + 32'd4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (out_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1.addr  <= pc_q;
			dec_s1.known <= cls.known;
			dec_s1.mnem  <= cls.mnem;
			dec_s1.word  <= instr_word;
		end
	end

endmodule

// ----- design/rid_queue.sv -----
module rid_queue #(
	parameter int DEPTH = rid_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rid_pkg::rid_dec_t in_dec,
	output logic              out_valid,
	input  logic              out_ready,
	output rid_pkg::rid_dec_t out_dec
);
	import rid_pkg::*;

	localparam int IdxW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	rid_dec_t        mem_q [DEPTH];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign in_ready  = (cnt_q != CntW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign do_push   = in_valid && in_ready;
	assign do_pop    = out_valid && out_ready;
	assign out_dec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= in_dec;
		end
	end

endmodule

// ----- design/rid_back.sv -----
module rid_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rid_pkg::rid_dec_t in_dec,
	output logic              empty,
	input  logic              pop,
	output rid_pkg::rid_res_t res
);
	import rid_pkg::*;

	logic        vld_s2;
	rid_res_t    res_s2;
	logic        load;
	logic [31:0] imm_ofs;

	assign in_ready = !vld_s2 || pop;
	assign load     = in_valid && in_ready;
	assign empty    = !vld_s2;
	assign res      = res_s2;
	// sign-extended immediate, word scaled
	assign imm_ofs  = {{14{in_dec.word[15]}}, in_dec.word[15:0], 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (load) begin
			vld_s2 <= 1'b1;
		end else if (pop) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2.addr  <= in_dec.addr;
			res_s2.known <= in_dec.known;
			res_s2.mnem  <= in_dec.mnem;
			res_s2.rs    <= in_dec.word[25:21];
			res_s2.rt    <= in_dec.word[20:16];
			res_s2.rd    <= in_dec.word[15:11];
			res_s2.shamt <= in_dec.word[10:6];
			res_s2.imm   <= $signed(in_dec.word[15:0]);
			res_s2.jidx  <= in_dec.word[25:0];
			res_s2.btgt  <= in_dec.addr + 32'd4 + imm_ofs;
		end
	end

endmodule

// ----- design/risc_instruction_decoder_core.sv -----
// Instruction decoder for the classic 32-bit load/store RISC set (first
// revision) with its own fetch counter. Push one 32-bit instruction word per
// cycle while full is low, in fetch order; each word yields exactly one
// result, popped from the result side in the same order. The word's address
// is the counter value at the transfer; the counter then steps by 4 and
// wraps at 2^32. It starts at 0x0040_0000 after reset, and a transfer on the
// configuration channel (always ready) loads start_address into it at once;
// write it only while no words are in flight. Results carry a dense mnemonic
// code 0..55 with a known flag (code 0 when not known), the raw register,
// shift, immediate and jump-index fields, and the branch target address + 4 +
// (immediate << 2). Throughput is one word per cycle in both directions while
// full is low and results are popped. From the input transfer the word sits
// in the classify register, moves into the decoupling queue and then into the
// output register, where the result shows. The input stalls only when the
// classify register, the queue of QUEUE_DEPTH entries (2 or more) and the
// output register are all occupied.
module risc_instruction_decoder_core #(
	parameter int QUEUE_DEPTH = rid_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        start_address,
	// instruction input
	input  logic               push,
	output logic               full,
	input  logic [31:0]        instr_word,
	// result output
	output logic               empty,
	input  logic               pop,
	output logic [31:0]        instr_address,
	output logic               known,
	output logic [5:0]         mnemonic,
	output logic [4:0]         rs,
	output logic [4:0]         rt,
	output logic [4:0]         rd,
	output logic [4:0]         shift_amount,
	output logic signed [15:0] immediate,
	output logic [25:0]        jump_index,
	output logic [31:0]        branch_target
);
	import rid_pkg::*;

	logic     fq_valid;
	logic     fq_ready;
	rid_dec_t fq_dec;
	logic     qb_valid;
	logic     qb_ready;
	rid_dec_t qb_dec;
	rid_res_t res;

	// counter load is a plain register write, never stalls
	assign cfg_ready = 1'b1;

	// front: counter, classification, one register stage
	rid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_data   (start_address),
		.push       (push),
		.full       (full),
		.instr_word (instr_word),
		.out_valid  (fq_valid),
		.out_ready  (fq_ready),
		.out_dec    (fq_dec)
	);

	// decoupling queue between classify and field/target generation
	rid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_dec    (fq_dec),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_dec   (qb_dec)
	);

	// back: field split, branch target add, output register
	rid_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (qb_valid),
		.in_ready (qb_ready),
		.in_dec   (qb_dec),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

	assign instr_address = res.addr;
	assign known         = res.known;
	assign mnemonic      = res.mnem;
	assign rs            = res.rs;
	assign rt            = res.rt;
	assign rd            = res.rd;
	assign shift_amount  = res.shamt;
	assign immediate     = res.imm;
	assign jump_index    = res.jidx;
	assign branch_target = res.btgt;

endmodule

// ----- design/rid_checker.sv -----
`include "risc_instruction_decoder_core_assert.svh"

module rid_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [31:0]        instr_address,
	input logic               known,
	input logic [5:0]         mnemonic,
	input logic [4:0]         rs,
	input logic [4:0]         rt,
	input logic [4:0]         rd,
	input logic [4:0]         shift_amount,
	input logic signed [15:0] immediate,
	input logic [25:0]        jump_index,
	input logic [31:0]        branch_target
);

	// a waiting result stays put until taken
	`RID_ASSERT_NXT(a_result_held, !empty && !pop, !empty && $stable(instr_address) && $stable(branch_target), "result changed while waiting")

	// unrecognised words report code zero; codes stay in range
	`RID_ASSERT_IMP(a_unknown_code, !empty && !known, mnemonic == 6'd0, "unknown word with nonzero code")
	`RID_ASSERT_IMP(a_code_range, !empty && known, mnemonic <= 6'd55, "mnemonic code out of range")

	// target follows the address and immediate of the same result
	`RID_ASSERT_IMP(a_branch_target, !empty, branch_target == instr_address + 32'd4 + (32'(immediate) << 2), "branch target mismatch")

	// all fields come from one word
	`RID_ASSERT_IMP(a_field_split, !empty, jump_index[25:21] == rs && jump_index[20:16] == rt && jump_index[15:11] == rd && jump_index[10:6] == shift_amount && jump_index[15:0] == $unsigned(immediate), "fields not from one word")

endmodule

bind risc_instruction_decoder_core rid_checker u_rid_checker (.*);
